### sv/bilinear_pixel_interpolator_macros.svh
// Assertion macros for the bilinear pixel interpolator.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef BILINEAR_PIXEL_INTERPOLATOR_MACROS_SVH
`define BILINEAR_PIXEL_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BPI_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed: label");
// Next-cycle implication, checked outside reset.
`define BPI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed: label");
`else
`define BPI_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BPI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/bpi_pkg.sv
// Shared types, codes and helpers of the bilinear pixel interpolator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package bpi_pkg;

    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned DIM_W     = 17;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned VALUE_W   = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } cfg_reg_t;

    // Operation and status codes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Access command from the control path to the pixel store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_cmd_t;

    // The 2x2 neighborhood: p<row offset><column offset>.
    typedef struct packed {
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p11;
    } quad_t;

    // A dimension register of zero acts as one; above the maximum it acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

### sv/bpi_store.sv
// Pixel store: four synchronous banks split by row and column parity.
// Any 2x2 neighborhood touches each bank once. Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_store #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  logic                           aclk,
    input  bpi_pkg::store_cmd_t            cmd,
    input  logic [$clog2(MAX_ROWS)-1:0]    wr_row,
    input  logic [$clog2(MAX_COLS)-1:0]    wr_col,
    input  logic [bpi_pkg::PIX_W-1:0]      wr_data,
    input  logic [$clog2(MAX_ROWS)-1:0]    rd_row,
    input  logic [$clog2(MAX_COLS)-1:0]    rd_col,
    output bpi_pkg::quad_t                 quad
);
    import bpi_pkg::*;

    localparam int unsigned HALF_ROWS = (MAX_ROWS + 1) / 2;
    localparam int unsigned HALF_COLS = (MAX_COLS + 1) / 2;
    localparam int unsigned HR_W      = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int unsigned HC_W      = (HALF_COLS > 1) ? $clog2(HALF_COLS) : 1;
    localparam int unsigned BANK_AW   = HR_W + HC_W;
    localparam int unsigned BANK_D    = 1 << BANK_AW;

    logic [PIX_W-1:0] rdata_reg [4];
    logic             row_odd_reg;
    logic             col_odd_reg;

    // One bank per parity pair; bank index is {row parity, column parity}.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = ((b / 2) == 1);
        localparam logic CP = ((b % 2) == 1);

        logic [PIX_W-1:0]   bank_mem [BANK_D];
        logic               bank_we;
        logic [BANK_AW-1:0] bank_waddr;
        logic [HR_W-1:0]    rd_row_half;
        logic [HC_W-1:0]    rd_col_half;

        // The even bank of an odd top-left index holds the next row or column.
        always_comb begin
            bank_we     = cmd.wr_en && (wr_row[0] == RP) && (wr_col[0] == CP);
            bank_waddr  = {HR_W'(wr_row >> 1), HC_W'(wr_col >> 1)};
            rd_row_half = HR_W'(rd_row >> 1) + HR_W'(rd_row[0] && !RP);
            rd_col_half = HC_W'(rd_col >> 1) + HC_W'(rd_col[0] && !CP);
        end

        always_ff @(posedge aclk) begin
            if (bank_we) begin
                bank_mem[bank_waddr] <= wr_data;
            end
            if (cmd.rd_en) begin
                rdata_reg[b] <= bank_mem[{rd_row_half, rd_col_half}];
            end
        end
    end

    // Remember the parity of the top-left pixel to route the banks.
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            row_odd_reg <= rd_row[0];
            col_odd_reg <= rd_col[0];
        end
    end

    always_comb begin
        quad.p00 = rdata_reg[{row_odd_reg, col_odd_reg}];
        quad.p01 = rdata_reg[{row_odd_reg, !col_odd_reg}];
        quad.p10 = rdata_reg[{!row_odd_reg, col_odd_reg}];
        quad.p11 = rdata_reg[{!row_odd_reg, !col_odd_reg}];
    end

endmodule

### sv/bpi_lerp.sv
// Two-stage blend datapath: horizontal lerps, then the vertical lerp.
// Each stage holds one signed multiply per lerp. Depends on bpi_pkg.
`timescale 1ns / 1ps

module bpi_lerp #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        en,
    input  bpi_pkg::quad_t              quad,
    input  logic [FRAC_BITS-1:0]        fx,
    input  logic [FRAC_BITS-1:0]        fy,
    output logic [8+2*FRAC_BITS-1:0]    val
);
    import bpi_pkg::*;

    localparam int unsigned T_W   = PIX_W + FRAC_BITS;
    localparam int unsigned VAL_W = T_W + FRAC_BITS;

    logic signed [PIX_W+1:0]           d_top;
    logic signed [PIX_W+1:0]           d_bot;
    logic signed [FRAC_BITS+PIX_W+2:0] m_top;
    logic signed [FRAC_BITS+PIX_W+2:0] m_bot;
    logic [T_W-1:0]                    top_next;
    logic [T_W-1:0]                    bot_next;
    logic [T_W-1:0]                    top_reg;
    logic [T_W-1:0]                    bot_reg;
    logic [FRAC_BITS-1:0]              fy_reg;
    logic signed [T_W:0]               d_v;
    logic signed [FRAC_BITS+T_W+1:0]   m_v;
    logic [VAL_W-1:0]                  val_next;
    logic [VAL_W-1:0]                  val_reg;

    // Horizontal blend: p0 * ONE + fx * (p1 - p0).
    always_comb begin
        d_top    = $signed({2'b00, quad.p01}) - $signed({2'b00, quad.p00});
        d_bot    = $signed({2'b00, quad.p11}) - $signed({2'b00, quad.p10});
        m_top    = $signed({1'b0, fx}) * d_top;
        m_bot    = $signed({1'b0, fx}) * d_bot;
        top_next = T_W'($signed({1'b0, quad.p00, {FRAC_BITS{1'b0}}}) + m_top);
        bot_next = T_W'($signed({1'b0, quad.p10, {FRAC_BITS{1'b0}}}) + m_bot);
    end

    // Vertical blend: top * ONE + fy * (bottom - top).
    always_comb begin
        d_v      = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        m_v      = $signed({1'b0, fy_reg}) * d_v;
        val_next = VAL_W'($signed({1'b0, top_reg, {FRAC_BITS{1'b0}}}) + m_v);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= fy;
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

### sv/bilinear_pixel_interpolator.sv
// Top level of the bilinear pixel interpolator: configuration, range checks,
// pipeline control and output register. Depends on bpi_pkg, bpi_store, bpi_lerp.
//
//   channel  | direction | handshake            | word
//   cfg      | in        | cfg_we               | cfg_addr, cfg_wdata
//   s_       | in        | s_valid / s_ready    | operation, pixel, coordinates
//   m_       | out       | m_valid / m_ready    | status, interpolated_value
//
// One word per cycle unless the output is stalled; a taken word passes s1, s2, then m_valid.
// Four parity banks give one read of the whole 2x2 neighborhood per cycle.
// Reset sets both image dimensions to 256, clamped to MAX_ROWS and MAX_COLS;
// the pixel store is not cleared and needs no pass after reset.
// s_ready drops only while the output register holds a word and m_ready is low.
`timescale 1ns / 1ps
`include "bilinear_pixel_interpolator_macros.svh"

module bilinear_pixel_interpolator #(
    parameter int unsigned MAX_ROWS  = 256,
    parameter int unsigned MAX_COLS  = 256,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bpi_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bpi_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [bpi_pkg::PIX_W-1:0]       s_pixel_row,
    input  logic [bpi_pkg::PIX_W-1:0]       s_pixel_col,
    input  logic [bpi_pkg::PIX_W-1:0]       s_pixel_value,
    input  logic [bpi_pkg::COORD_W-1:0]     s_coord_x,
    input  logic [bpi_pkg::COORD_W-1:0]     s_coord_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [bpi_pkg::VALUE_W-1:0]     m_interpolated_value
);
    import bpi_pkg::*;

    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned COL_W = $clog2(MAX_COLS);
    localparam int unsigned VAL_W = PIX_W + 2 * FRAC_BITS;
    localparam logic [DIM_W-1:0] ROWS_RST = clamp_dim(CFG_W'(256), DIM_W'(MAX_ROWS));
    localparam logic [DIM_W-1:0] COLS_RST = clamp_dim(CFG_W'(256), DIM_W'(MAX_COLS));

    logic [DIM_W-1:0]     rows_reg, rows_next;
    logic [DIM_W-1:0]     cols_reg, cols_next;
    logic                 advance;
    logic                 accept;
    logic [COORD_W-1:0]   ix;
    logic [COORD_W-1:0]   iy;
    logic                 w_in_range;
    logic                 q_in_range;
    logic                 in_status;
    logic                 in_zero;
    store_cmd_t           cmd;
    quad_t                quad;
    logic [VAL_W-1:0]     val;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 s1_status_reg, s2_status_reg, m_status_reg;
    logic                 s1_zero_reg, s2_zero_reg, m_zero_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg, s1_fy_reg;

    // Configuration: dimensions are kept already clamped.
    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_ROWS: rows_next = clamp_dim(cfg_wdata, DIM_W'(MAX_ROWS));
                REG_IMAGE_COLS: cols_next = clamp_dim(cfg_wdata, DIM_W'(MAX_COLS));
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RST;
            cols_reg <= COLS_RST;
        end else begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // The whole pipeline moves unless the output word is stalled.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Range checks: a write needs its pixel inside, a query its whole neighborhood.
    always_comb begin
        ix         = s_coord_x >> FRAC_BITS;
        iy         = s_coord_y >> FRAC_BITS;
        w_in_range = (DIM_W'(s_pixel_row) < rows_reg) && (DIM_W'(s_pixel_col) < cols_reg);
        q_in_range = ((DIM_W'(ix) + DIM_W'(1)) < cols_reg)
                  && ((DIM_W'(iy) + DIM_W'(1)) < rows_reg);
        if (s_operation == OP_WRITE) begin
            in_status = w_in_range ? STATUS_OK : STATUS_ERR;
            in_zero   = 1'b1;
        end else begin
            in_status = q_in_range ? STATUS_OK : STATUS_ERR;
            in_zero   = !q_in_range;
        end
        cmd.wr_en = accept && (s_operation == OP_WRITE) && w_in_range;
        cmd.rd_en = accept && (s_operation == OP_QUERY);
    end

    // Writes land and queries read at the accepting edge, so order is kept.
    bpi_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .aclk    (aclk),
        .cmd     (cmd),
        .wr_row  (ROW_W'(s_pixel_row)),
        .wr_col  (COL_W'(s_pixel_col)),
        .wr_data (s_pixel_value),
        .rd_row  (ROW_W'(iy)),
        .rd_col  (COL_W'(ix)),
        .quad    (quad)
    );

    bpi_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .aclk (aclk),
        .en   (advance),
        .quad (quad),
        .fx   (s1_fx_reg),
        .fy   (s1_fy_reg),
        .val  (val)
    );

    // Valid bits of the three stages.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        m_valid_next  = m_valid_reg;
        if (advance) begin
            s1_valid_next = accept;
            s2_valid_next = s1_valid_reg;
            m_valid_next  = s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Side information travels beside the datapath.
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_status_reg <= in_status;
            s1_zero_reg   <= in_zero;
            s1_fx_reg     <= s_coord_x[FRAC_BITS-1:0];
            s1_fy_reg     <= s_coord_y[FRAC_BITS-1:0];
            s2_status_reg <= s1_status_reg;
            s2_zero_reg   <= s1_zero_reg;
            m_status_reg  <= s2_status_reg;
            m_zero_reg    <= s2_zero_reg;
        end
    end

    // Writes and rejected queries report a zero value.
    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_interpolated_value = m_zero_reg ? '0 : VALUE_W'(val);

    `BPI_ASSERT_NOW(a_no_rw_clash, aclk, aresetn, cmd.wr_en, !cmd.rd_en)
    `BPI_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)
    `BPI_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, s1_valid_reg)
    `BPI_ASSERT_NOW(a_err_is_zero, aclk, aresetn, m_valid && (m_status == STATUS_ERR), m_interpolated_value == '0)

endmodule

### test/bilinear_pixel_interpolator_test.sv
// Self-checking testbench for bilinear_pixel_interpolator: pixel writes and 2x2 bilinear
// queries are predicted in order and every result word is checked field by field.
// Depends on bpi_pkg and the bilinear_pixel_interpolator RTL; reads no files.
`timescale 1ns / 1ps

module bilinear_pixel_interpolator_test;
    import bpi_pkg::*;

    localparam int unsigned MAX_ROWS    = 256;
    localparam int unsigned MAX_COLS    = 256;
    localparam int unsigned FRAC_BITS   = 8;
    localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned FRAC_ONE    = 1 << FRAC_BITS;
    localparam int unsigned TAIL_CYCLES = 10;

    // One input word and one result word as the ports carry them.
    typedef struct packed {
        logic               operation;
        logic [PIX_W-1:0]   row;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } pixel_word_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value;
    } blend_result_t;

    // Block inputs, all driven to known values from time zero.
    logic               aclk                 = 1'b0;
    logic               aresetn              = 1'b0;
    logic               cfg_we               = 1'b0;
    cfg_reg_t           cfg_addr             = REG_IMAGE_ROWS;
    logic [CFG_W-1:0]   cfg_wdata            = '0;
    logic               s_valid              = 1'b0;
    logic               s_ready;
    logic               s_operation          = OP_WRITE;
    logic [PIX_W-1:0]   s_pixel_row          = '0;
    logic [PIX_W-1:0]   s_pixel_col          = '0;
    logic [PIX_W-1:0]   s_pixel_value        = '0;
    logic [COORD_W-1:0] s_coord_x            = '0;
    logic [COORD_W-1:0] s_coord_y            = '0;
    logic               m_valid;
    logic               m_ready              = 1'b0;
    logic               m_status;
    logic [VALUE_W-1:0] m_interpolated_value;

    // Predicted image, which pixels hold a written value, and the image size in use.
    logic [PIX_W-1:0]     image_copy [STORE_DEPTH];
    bit [STORE_DEPTH-1:0] pixel_known  = '0;
    int unsigned          rows_in_use  = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    int unsigned          cols_in_use  = (MAX_COLS < 256) ? MAX_COLS : 256;

    // Fully written rectangle that in-range queries fall back on.
    int unsigned region_r0, region_c0, region_h, region_w;

    blend_result_t predicted_outputs [$];
    int            mismatch_count = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;
    int            stall_hold     = 0;

    bilinear_pixel_interpolator #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_pixel_row          (s_pixel_row),
        .s_pixel_col          (s_pixel_col),
        .s_pixel_value        (s_pixel_value),
        .s_coord_x            (s_coord_x),
        .s_coord_y            (s_coord_y),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_interpolated_value (m_interpolated_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A register of zero means one row or column; anything above the maximum means the maximum.
    function automatic int unsigned effective_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) begin
            return 1;
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    function automatic bit quad_inside(input int unsigned iy, input int unsigned ix);
        return (ix + 1 < cols_in_use) && (iy + 1 < rows_in_use);
    endfunction

    // True when the whole neighborhood lies in the image and every pixel of it was written.
    function automatic bit quad_written(input int unsigned iy, input int unsigned ix);
        int unsigned a;
        if (!quad_inside(iy, ix)) begin
            return 1'b0;
        end
        a = iy * cols_in_use + ix;
        return pixel_known[a] && pixel_known[a + 1] && pixel_known[a + cols_in_use]
            && pixel_known[a + cols_in_use + 1];
    endfunction

    // Stores a write in the image copy, or blends the 2x2 neighborhood of a query.
    function automatic blend_result_t interpolate_or_store(input pixel_word_t w);
        blend_result_t r;
        int unsigned   ix, iy, fx, fy, a, top, bot;
        r.status = STATUS_OK;
        r.value  = '0;
        if (w.operation == OP_WRITE) begin
            if (w.row < rows_in_use && w.col < cols_in_use) begin
                a              = w.row * cols_in_use + w.col;
                image_copy[a]  = w.value;
                pixel_known[a] = 1'b1;
            end else begin
                r.status = STATUS_ERR;
            end
            return r;
        end
        ix = w.coord_x >> FRAC_BITS;
        iy = w.coord_y >> FRAC_BITS;
        fx = w.coord_x & (FRAC_ONE - 1);
        fy = w.coord_y & (FRAC_ONE - 1);
        if (!quad_inside(iy, ix)) begin
            r.status = STATUS_ERR;
            return r;
        end
        a   = iy * cols_in_use + ix;
        top = (FRAC_ONE - fx) * image_copy[a] + fx * image_copy[a + 1];
        bot = (FRAC_ONE - fx) * image_copy[a + cols_in_use]
            + fx * image_copy[a + cols_in_use + 1];
        r.value = VALUE_W'((FRAC_ONE - fy) * top + fy * bot);
        return r;
    endfunction

    // Word builders; the fields that the operation ignores carry random bits.
    function automatic pixel_word_t write_word(input int unsigned row, input int unsigned col,
                                               input int unsigned val);
        pixel_word_t w;
        w.operation = OP_WRITE;
        w.row       = PIX_W'(row);
        w.col       = PIX_W'(col);
        w.value     = PIX_W'(val);
        w.coord_x   = COORD_W'($urandom);
        w.coord_y   = COORD_W'($urandom);
        return w;
    endfunction

    function automatic pixel_word_t query_word(input int unsigned x, input int unsigned y);
        pixel_word_t w;
        w.operation = OP_QUERY;
        w.row       = PIX_W'($urandom);
        w.col       = PIX_W'($urandom);
        w.value     = PIX_W'($urandom);
        w.coord_x   = COORD_W'(x);
        w.coord_y   = COORD_W'(y);
        return w;
    endfunction

    // Any coordinates; a neighborhood that is inside but not fully written is pushed out.
    function automatic pixel_word_t noise_query();
        logic [COORD_W-1:0] x, y;
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        if (quad_inside(y >> FRAC_BITS, x >> FRAC_BITS)
                && !quad_written(y >> FRAC_BITS, x >> FRAC_BITS)) begin
            x[COORD_W-1:FRAC_BITS] = '1;
        end
        return query_word(x, y);
    endfunction

    // A query whose neighborhood is fully written, with random fractions; a noise query if no region fits.
    function automatic pixel_word_t written_query();
        int unsigned iy, ix;
        if (region_h < 2 || region_w < 2) begin
            return noise_query();
        end
        iy = $urandom_range(rows_in_use - 2);
        ix = $urandom_range(cols_in_use - 2);
        if (!quad_written(iy, ix)) begin
            iy = region_r0 + $urandom_range(region_h - 2);
            ix = region_c0 + $urandom_range(region_w - 2);
        end
        return query_word((ix << FRAC_BITS) | $urandom_range(FRAC_ONE - 1),
                          (iy << FRAC_BITS) | $urandom_range(FRAC_ONE - 1));
    endfunction

    function automatic pixel_word_t random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            if ($urandom_range(9) < 7) begin
                return write_word($urandom_range(rows_in_use - 1),
                                  $urandom_range(cols_in_use - 1), $urandom_range(255));
            end
            return write_word($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end else if (pick < 85) begin
            return written_query();
        end
        return noise_query();
    endfunction

    // Offers one word, with an optional idle gap first, and predicts it once taken.
    task automatic send_word(input pixel_word_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            if (s_valid) begin
                s_valid <= 1'b0;
            end
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_operation   <= w.operation;
        s_pixel_row   <= w.row;
        s_pixel_col   <= w.col;
        s_pixel_value <= w.value;
        s_coord_x     <= w.coord_x;
        s_coord_y     <= w.coord_y;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted_outputs.push_back(interpolate_or_store(w));
    endtask

    // Stops offering words and waits until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (predicted_outputs.size() != 0);
    endtask

    // Sets the image size while the block is idle; the old layout no longer counts as written.
    task automatic set_dims(input int unsigned rows_val, input int unsigned cols_val);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_ROWS;
        cfg_wdata <= CFG_W'(rows_val);
        @(posedge aclk);
        rows_in_use = effective_dim(rows_val, MAX_ROWS);
        cfg_addr  <= REG_IMAGE_COLS;
        cfg_wdata <= CFG_W'(cols_val);
        @(posedge aclk);
        cols_in_use = effective_dim(cols_val, MAX_COLS);
        cfg_we <= 1'b0;
        pixel_known = '0;
        region_h    = 0;
        region_w    = 0;
    endtask

    // Writes a random rectangle of the image, often placed at the bottom-right corner.
    task automatic fill_region();
        int unsigned r, c;
        region_h  = (rows_in_use < 2) ? rows_in_use : 2 + $urandom_range(rows_in_use < 8 ?
                                                                  rows_in_use - 2 : 6);
        region_w  = (cols_in_use < 2) ? cols_in_use : 2 + $urandom_range(cols_in_use < 8 ?
                                                                  cols_in_use - 2 : 6);
        region_r0 = $urandom_range(1) ? rows_in_use - region_h
                                      : $urandom_range(rows_in_use - region_h);
        region_c0 = $urandom_range(1) ? cols_in_use - region_w
                                      : $urandom_range(cols_in_use - region_w);
        for (r = region_r0; r < region_r0 + region_h; r++) begin
            for (c = region_c0; c < region_c0 + region_w; c++) begin
                send_word(write_word(r, c, $urandom_range(255)));
            end
        end
    endtask

    // Reset image size, extreme pixel values and fractions, and the far corner.
    task automatic test_reset_image_size();
        send_word(write_word(0, 0, 0));
        send_word(write_word(0, 1, 255));
        send_word(write_word(1, 0, 255));
        send_word(write_word(1, 1, 0));
        send_word(query_word(16'h0000, 16'h0000));
        send_word(query_word(16'h00FF, 16'h00FF));
        send_word(query_word(16'h0080, 16'h0000));
        send_word(query_word(16'h0000, 16'h00FF));
        send_word(write_word(254, 254, 255));
        send_word(write_word(254, 255, 128));
        send_word(write_word(255, 254, 1));
        send_word(write_word(255, 255, 255));
        send_word(query_word(16'hFEFF, 16'hFEFF));
        send_word(query_word(16'hFE00, 16'hFE80));
        // Top-left pixel on the last column or row: the neighborhood leaves the image.
        send_word(query_word(16'hFF00, 16'h0000));
        send_word(query_word(16'hFFFF, 16'hFFFF));
    endtask

    // A zero row count acts as one row, and an oversized column count as the maximum.
    task automatic test_degenerate_dims();
        set_dims(0, 511);
        send_word(write_word(0, 255, 77));
        send_word(write_word(1, 0, 5));
        send_word(query_word(16'h0000, 16'h0000));
    endtask

    // The smallest image that has a neighborhood, and the edges around it.
    task automatic test_smallest_quad();
        set_dims(2, 2);
        send_word(write_word(0, 0, 200));
        send_word(write_word(0, 1, 10));
        send_word(write_word(1, 0, 99));
        send_word(write_word(1, 1, 255));
        send_word(query_word(16'h0040, 16'h00C0));
        // Zero fraction still needs the next column inside the image.
        send_word(query_word(16'h0100, 16'h0000));
        send_word(write_word(2, 0, 1));
        send_word(write_word(0, 2, 1));
    endtask

    task automatic test_random_traffic(input int unsigned rows_val, input int unsigned cols_val,
                                       input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned n_words);
        set_dims(rows_val, cols_val);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        fill_region();
        repeat (n_words) send_word(random_word());
    endtask

    // The receiver holds off long enough to fill the pipeline, then the sender pauses; random stalls follow.
    task automatic test_output_backpressure();
        set_dims(8, 8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_region();
        stall_hold = 200;
        repeat (50) send_word(random_word());
        wait_drained();
        recv_stall_pct = 30;
        repeat (30) send_word(random_word());
    endtask

    // Result side: random stalls, plus a long hold-off counted down here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each result word is checked against the oldest prediction.
    always @(posedge aclk) begin
        blend_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (predicted_outputs.size() == 0) begin
                $error("result word with none predicted: status %0d, value %0d",
                       m_status, m_interpolated_value);
                mismatch_count++;
            end else begin
                want = predicted_outputs.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatch_count++;
                end
                if (m_interpolated_value !== want.value) begin
                    $error("interpolated_value: expected %0d, got %0d",
                           want.value, m_interpolated_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_image_size();
        test_degenerate_dims();
        test_smallest_quad();
        test_random_traffic(256, 256, 0, 0, 100);
        test_random_traffic(12, 7, 78, 0, 100);
        test_random_traffic(5, 300, 0, 78, 100);
        test_random_traffic(2, 2, 16, 16, 80);
        test_random_traffic(16, 40, 0, 0, 60);
        test_output_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
            $display("PASS bilinear_pixel_interpolator");
        end else begin
            $display("FAIL bilinear_pixel_interpolator");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(64'd10_000_000);
        $display("FAIL bilinear_pixel_interpolator");
        $finish;
    end

endmodule
